// ===== rtl/lbbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbbc_pkg;

    localparam int ENTRIES_DEF  = 32;
    localparam int DEVICES_DEF  = 16;
    localparam int REF_BITS_DEF = 8;

    // Recency links carry an entry number or the end-of-list mark.
    localparam int              LINK_W    = 6;
    localparam logic [LINK_W-1:0] LINK_NONE = 6'd63;

    localparam int N_CNT     = 5;
    localparam int CNT_HIT   = 0;
    localparam int CNT_MISS  = 1;
    localparam int CNT_EVICT = 2;
    localparam int CNT_WB    = 3;
    localparam int CNT_FAIL  = 4;

    typedef logic [2:0] t_func;
    localparam t_func FN_GET     = 3'd0;
    localparam t_func FN_RELEASE = 3'd1;
    localparam t_func FN_DIRTY   = 3'd2;
    localparam t_func FN_FLUSH   = 3'd3;
    localparam t_func FN_SYNC    = 3'd4;
    localparam t_func FN_INVAL   = 3'd5;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_NOCACHE = 3'd1;
    localparam t_status ST_NOFREE  = 3'd2;
    localparam t_status ST_WFAIL   = 3'd3;
    localparam t_status ST_RFAIL   = 3'd4;
    localparam t_status ST_HELD    = 3'd5;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_WB    = 2'd0;
    localparam t_kind KIND_READ  = 2'd1;
    localparam t_kind KIND_FINAL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_HSCAN,
        S_VWALK,
        S_WB_EMIT,
        S_READ_EMIT,
        S_SYNC,
        S_INV_HELD,
        S_INV_RD,
        S_INV_CHK,
        S_FINAL
    } t_state;

    typedef enum logic [1:0] {
        LK_NONE,
        LK_NEWEST,
        LK_OLDEST
    } t_link_op;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  device_id;
        logic [63:0] block_number;
        logic [4:0]  entry_index;
        logic        size_ok;
        logic        device_ok;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [2:0]  status;
        logic [4:0]  entry_out;
        logic [3:0]  xfer_device;
        logic [63:0] xfer_block;
        logic        hit_flag;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [31:0] evictions_total;
        logic [31:0] writebacks_total;
        logic [31:0] failures_total;
    } t_out;

    typedef struct packed {
        logic [3:0]  dev;
        logic [63:0] blk;
    } t_tag;

endpackage

`default_nettype wire

// ===== rtl/lru_block_buffer_cache.sv =====
// A get scans the tag memory through its one read port, one entry per cycle, for a hit; a miss
// walks the recency list from the oldest entry for a victim, then the results are emitted.
// Sync writes back each dirty entry; invalidate scans twice, for held entries and to drop them.
// One transaction is in flight at a time; the input stalls meanwhile.
// Reset clears flags, reference counts and counters and restores the recency order at once;
// the tag memory needs no clearing pass since no entry is valid after reset.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_buffer_cache #(
    parameter int ENTRIES  = lbbc_pkg::ENTRIES_DEF,
    parameter int DEVICES  = lbbc_pkg::DEVICES_DEF,
    parameter int REF_BITS = lbbc_pkg::REF_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire lbbc_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output lbbc_pkg::t_out     o_data
);

    localparam int LW = lbbc_pkg::LINK_W;
    localparam int IW = $clog2(ENTRIES);
    localparam logic [LW-1:0] N_L = LW'(ENTRIES);
    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    typedef logic [LW-1:0] t_link;

    lbbc_pkg::t_state r_state, n_state;
    lbbc_pkg::t_in    r_req, n_req;

    t_link r_e, n_e;
    t_link r_ce, n_ce;
    t_link r_steps, n_steps;

    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [ENTRIES-1:0]  r_dirty, n_dirty;
    logic [REF_BITS-1:0] r_ref [ENTRIES];
    logic [REF_BITS-1:0] n_ref [ENTRIES];
    t_link r_newer [ENTRIES];
    t_link n_newer [ENTRIES];
    t_link r_older [ENTRIES];
    t_link n_older [ENTRIES];
    t_link r_oldest, n_oldest;
    t_link r_newest, n_newest;

    logic [31:0] r_cnt [lbbc_pkg::N_CNT];
    logic [31:0] n_cnt [lbbc_pkg::N_CNT];
    logic [lbbc_pkg::N_CNT-1:0] bump;

    lbbc_pkg::t_status r_fst, n_fst;
    t_link             r_fent, n_fent;
    logic [3:0]        r_fdev, n_fdev;
    logic [63:0]       r_fblk, n_fblk;
    logic              r_fhit, n_fhit;
    logic              r_evict, n_evict;

    lbbc_pkg::t_out r_out, n_out;
    logic           r_out_valid;
    logic           emit;

    lbbc_pkg::t_tag m_tag [ENTRIES];
    lbbc_pkg::t_tag r_rdata;
    logic           rd_en, wr_en;
    logic [IW-1:0]  rd_addr, wr_addr;
    lbbc_pkg::t_tag wr_data;

    lbbc_pkg::t_link_op lk_op;
    t_link              lk_e;

    logic [IW-1:0] e_i, ce_i, idx_i;
    t_link         idx_l;
    logic          idx_in, dev_in, e_in, ok, out_free;
    logic          hit_m, held_m, scan_last, victim, inv_match;

    assign e_i       = r_e[IW-1:0];
    assign ce_i      = r_ce[IW-1:0];
    assign idx_l     = {1'b0, r_req.entry_index};
    assign idx_i     = idx_l[IW-1:0];
    assign idx_in    = idx_l < N_L;
    assign dev_in    = {28'd0, r_req.device_id} < 32'(DEVICES);
    assign e_in      = r_e < N_L;
    assign ok        = r_req.device_ok;
    assign out_free  = !r_out_valid || !i_stall;
    assign scan_last = (r_e == N_L);
    assign hit_m     = r_valid[ce_i] && (r_rdata.dev == r_req.device_id)
                       && (r_rdata.blk == r_req.block_number);
    assign held_m    = r_valid[ce_i] && (r_rdata.dev == r_req.device_id)
                       && (r_ref[ce_i] != '0);
    assign victim    = e_in && (r_ref[e_i] == '0);
    assign inv_match = r_valid[e_i] && (r_rdata.dev == r_req.device_id);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbbc_pkg::S_IDLE: begin
                if (i_valid) n_state = lbbc_pkg::S_DISPATCH;
            end
            lbbc_pkg::S_DISPATCH: begin
                unique case (r_req.func)
                    lbbc_pkg::FN_GET: begin
                        if (!r_req.size_ok || !dev_in) n_state = lbbc_pkg::S_FINAL;
                        else n_state = lbbc_pkg::S_HSCAN;
                    end
                    lbbc_pkg::FN_FLUSH: begin
                        if (idx_in && r_valid[idx_i] && r_dirty[idx_i])
                            n_state = lbbc_pkg::S_WB_EMIT;
                        else n_state = lbbc_pkg::S_FINAL;
                    end
                    lbbc_pkg::FN_SYNC: n_state = lbbc_pkg::S_SYNC;
                    lbbc_pkg::FN_INVAL: begin
                        if (dev_in) n_state = lbbc_pkg::S_INV_HELD;
                        else n_state = lbbc_pkg::S_FINAL;
                    end
                    default: n_state = lbbc_pkg::S_FINAL;
                endcase
            end
            lbbc_pkg::S_HSCAN: begin
                if (hit_m) n_state = lbbc_pkg::S_FINAL;
                else if (scan_last) n_state = lbbc_pkg::S_VWALK;
            end
            lbbc_pkg::S_VWALK: begin
                if (victim) begin
                    if (r_valid[e_i] && r_dirty[e_i]) n_state = lbbc_pkg::S_WB_EMIT;
                    else n_state = lbbc_pkg::S_READ_EMIT;
                end else if (!e_in || r_steps == N_L) begin
                    n_state = lbbc_pkg::S_FINAL;
                end
            end
            lbbc_pkg::S_WB_EMIT: begin
                if (out_free) begin
                    unique case (r_req.func)
                        lbbc_pkg::FN_GET: begin
                            if (ok) n_state = lbbc_pkg::S_READ_EMIT;
                            else n_state = lbbc_pkg::S_FINAL;
                        end
                        lbbc_pkg::FN_SYNC:  n_state = lbbc_pkg::S_SYNC;
                        lbbc_pkg::FN_INVAL: n_state = lbbc_pkg::S_INV_RD;
                        default:            n_state = lbbc_pkg::S_FINAL;
                    endcase
                end
            end
            lbbc_pkg::S_READ_EMIT: begin
                if (out_free) n_state = lbbc_pkg::S_FINAL;
            end
            lbbc_pkg::S_SYNC: begin
                if (!e_in) n_state = lbbc_pkg::S_FINAL;
                else if (r_valid[e_i] && r_dirty[e_i]) n_state = lbbc_pkg::S_WB_EMIT;
            end
            lbbc_pkg::S_INV_HELD: begin
                if (held_m) n_state = lbbc_pkg::S_FINAL;
                else if (scan_last) n_state = lbbc_pkg::S_INV_RD;
            end
            lbbc_pkg::S_INV_RD: begin
                if (!e_in) n_state = lbbc_pkg::S_FINAL;
                else n_state = lbbc_pkg::S_INV_CHK;
            end
            lbbc_pkg::S_INV_CHK: begin
                if (inv_match && r_dirty[e_i]) n_state = lbbc_pkg::S_WB_EMIT;
                else n_state = lbbc_pkg::S_INV_RD;
            end
            lbbc_pkg::S_FINAL: begin
                if (out_free) n_state = lbbc_pkg::S_IDLE;
            end
            default: n_state = lbbc_pkg::S_IDLE;
        endcase
    end

    // Datapath actions of each state.
    always_comb begin
        n_req     = r_req;
        n_e       = r_e;
        n_ce      = r_ce;
        n_steps   = r_steps;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_ref     = r_ref;
        n_fst     = r_fst;
        n_fent    = r_fent;
        n_fdev    = r_fdev;
        n_fblk    = r_fblk;
        n_fhit    = r_fhit;
        n_evict   = r_evict;
        bump      = '0;
        rd_en     = 1'b0;
        rd_addr   = e_i;
        wr_en     = 1'b0;
        wr_addr   = e_i;
        wr_data   = '{dev: r_req.device_id, blk: r_req.block_number};
        lk_op     = lbbc_pkg::LK_NONE;
        lk_e      = r_e;
        emit      = 1'b0;
        n_out     = '0;
        n_out.kind        = lbbc_pkg::KIND_FINAL;
        n_out.entry_out   = r_e[4:0];
        n_out.xfer_device = r_rdata.dev;
        n_out.xfer_block  = r_rdata.blk;

        unique case (r_state)
            lbbc_pkg::S_IDLE: begin
                if (i_valid) n_req = i_data;
            end
            lbbc_pkg::S_DISPATCH: begin
                n_fst   = lbbc_pkg::ST_OK;
                n_fent  = '0;
                n_fdev  = '0;
                n_fblk  = '0;
                n_fhit  = 1'b0;
                n_evict = 1'b0;
                unique case (r_req.func)
                    lbbc_pkg::FN_GET: begin
                        if (!r_req.size_ok || !dev_in) begin
                            n_fst = lbbc_pkg::ST_NOCACHE;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_ce    = '0;
                            n_e     = LW'(1);
                        end
                    end
                    lbbc_pkg::FN_RELEASE: begin
                        if (idx_in && r_ref[idx_i] != '0)
                            n_ref[idx_i] = r_ref[idx_i] - REF_BITS'(1);
                    end
                    lbbc_pkg::FN_DIRTY: begin
                        if (idx_in && r_valid[idx_i]) n_dirty[idx_i] = 1'b1;
                    end
                    lbbc_pkg::FN_FLUSH: begin
                        if (!idx_in) begin
                            n_fst = lbbc_pkg::ST_WFAIL;
                        end else if (r_valid[idx_i] && r_dirty[idx_i]) begin
                            rd_en   = 1'b1;
                            rd_addr = idx_i;
                            n_e     = idx_l;
                        end
                    end
                    lbbc_pkg::FN_SYNC: n_e = '0;
                    lbbc_pkg::FN_INVAL: begin
                        if (dev_in) begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_ce    = '0;
                            n_e     = LW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            lbbc_pkg::S_HSCAN: begin
                if (hit_m) begin
                    bump[lbbc_pkg::CNT_HIT] = 1'b1;
                    lk_op = lbbc_pkg::LK_NEWEST;
                    lk_e  = r_ce;
                    if (r_ref[ce_i] != REF_MAX) n_ref[ce_i] = r_ref[ce_i] + REF_BITS'(1);
                    n_fent = r_ce;
                    n_fdev = r_req.device_id;
                    n_fblk = r_req.block_number;
                    n_fhit = 1'b1;
                end else if (scan_last) begin
                    bump[lbbc_pkg::CNT_MISS] = 1'b1;
                    n_e     = r_oldest;
                    n_steps = '0;
                end else begin
                    rd_en = 1'b1;
                    n_ce  = r_e;
                    n_e   = r_e + LW'(1);
                end
            end
            lbbc_pkg::S_VWALK: begin
                if (victim) begin
                    if (r_valid[e_i]) begin
                        if (r_dirty[e_i]) rd_en = 1'b1;
                        else n_evict = 1'b1;
                    end
                end else if (!e_in || r_steps == N_L) begin
                    n_fst = lbbc_pkg::ST_NOFREE;
                end else begin
                    n_e     = r_newer[e_i];
                    n_steps = r_steps + LW'(1);
                end
            end
            lbbc_pkg::S_WB_EMIT: begin
                emit         = 1'b1;
                n_out.kind   = lbbc_pkg::KIND_WB;
                n_out.status = ok ? lbbc_pkg::ST_OK : lbbc_pkg::ST_WFAIL;
                if (out_free) begin
                    if (ok) begin
                        bump[lbbc_pkg::CNT_WB] = 1'b1;
                        n_dirty[e_i] = 1'b0;
                    end else begin
                        bump[lbbc_pkg::CNT_FAIL] = 1'b1;
                        n_fst = lbbc_pkg::ST_WFAIL;
                    end
                    unique case (r_req.func)
                        lbbc_pkg::FN_GET: n_evict = ok;
                        lbbc_pkg::FN_SYNC: n_e = r_e + LW'(1);
                        lbbc_pkg::FN_INVAL: begin
                            if (ok) begin
                                n_valid[e_i] = 1'b0;
                                n_dirty[e_i] = 1'b0;
                                lk_op = lbbc_pkg::LK_OLDEST;
                            end
                            n_e = r_e + LW'(1);
                        end
                        default: ;
                    endcase
                end
            end
            lbbc_pkg::S_READ_EMIT: begin
                emit              = 1'b1;
                n_out.kind        = lbbc_pkg::KIND_READ;
                n_out.status      = ok ? lbbc_pkg::ST_OK : lbbc_pkg::ST_RFAIL;
                n_out.xfer_device = r_req.device_id;
                n_out.xfer_block  = r_req.block_number;
                if (out_free) begin
                    bump[lbbc_pkg::CNT_EVICT] = r_evict;
                    n_dirty[e_i] = 1'b0;
                    if (!ok) begin
                        bump[lbbc_pkg::CNT_FAIL] = 1'b1;
                        n_valid[e_i] = 1'b0;
                        n_fst = lbbc_pkg::ST_RFAIL;
                    end else begin
                        n_valid[e_i] = 1'b1;
                        n_ref[e_i]   = REF_BITS'(1);
                        wr_en  = 1'b1;
                        lk_op  = lbbc_pkg::LK_NEWEST;
                        n_fent = r_e;
                        n_fdev = r_req.device_id;
                        n_fblk = r_req.block_number;
                    end
                end
            end
            lbbc_pkg::S_SYNC: begin
                if (e_in) begin
                    if (r_valid[e_i] && r_dirty[e_i]) rd_en = 1'b1;
                    else n_e = r_e + LW'(1);
                end
            end
            lbbc_pkg::S_INV_HELD: begin
                if (held_m) begin
                    n_fst = lbbc_pkg::ST_HELD;
                end else if (scan_last) begin
                    n_e = '0;
                end else begin
                    rd_en = 1'b1;
                    n_ce  = r_e;
                    n_e   = r_e + LW'(1);
                end
            end
            lbbc_pkg::S_INV_RD: begin
                if (e_in) rd_en = 1'b1;
            end
            lbbc_pkg::S_INV_CHK: begin
                if (inv_match && !r_dirty[e_i]) begin
                    n_valid[e_i] = 1'b0;
                    lk_op = lbbc_pkg::LK_OLDEST;
                    n_e   = r_e + LW'(1);
                end else if (!inv_match) begin
                    n_e = r_e + LW'(1);
                end
            end
            lbbc_pkg::S_FINAL: begin
                emit              = 1'b1;
                n_out.last        = 1'b1;
                n_out.status      = r_fst;
                n_out.entry_out   = r_fent[4:0];
                n_out.xfer_device = r_fdev;
                n_out.xfer_block  = r_fblk;
                n_out.hit_flag    = r_fhit;
            end
            default: ;
        endcase

        n_out.hits_total       = n_cnt[lbbc_pkg::CNT_HIT];
        n_out.misses_total     = n_cnt[lbbc_pkg::CNT_MISS];
        n_out.evictions_total  = n_cnt[lbbc_pkg::CNT_EVICT];
        n_out.writebacks_total = n_cnt[lbbc_pkg::CNT_WB];
        n_out.failures_total   = n_cnt[lbbc_pkg::CNT_FAIL];
    end

    always_comb begin
        for (int i = 0; i < lbbc_pkg::N_CNT; i++) begin
            n_cnt[i] = r_cnt[i];
            if (bump[i] && r_cnt[i] != 32'hFFFF_FFFF) n_cnt[i] = r_cnt[i] + 32'd1;
        end
    end

    // Recency list update: unlink the entry, then put it at the new or the old end.
    always_comb begin
        t_link         o_l, w_l;
        logic [IW-1:0] lk_i;
        o_l      = '0;
        w_l      = '0;
        lk_i     = lk_e[IW-1:0];
        n_newer  = r_newer;
        n_older  = r_older;
        n_oldest = r_oldest;
        n_newest = r_newest;
        if (lk_op != lbbc_pkg::LK_NONE) begin
            o_l = r_older[lk_i];
            w_l = r_newer[lk_i];
            if (w_l < N_L) n_older[w_l[IW-1:0]] = o_l;
            else n_newest = o_l;
            if (o_l < N_L) n_newer[o_l[IW-1:0]] = w_l;
            else n_oldest = w_l;
            if (lk_op == lbbc_pkg::LK_NEWEST) begin
                n_older[lk_i] = n_newest;
                n_newer[lk_i] = lbbc_pkg::LINK_NONE;
                if (n_newest < N_L) n_newer[n_newest[IW-1:0]] = lk_e;
                n_newest = lk_e;
                if (!(n_oldest < N_L)) n_oldest = lk_e;
            end else begin
                n_newer[lk_i] = n_oldest;
                n_older[lk_i] = lbbc_pkg::LINK_NONE;
                if (n_oldest < N_L) n_older[n_oldest[IW-1:0]] = lk_e;
                n_oldest = lk_e;
                if (!(n_newest < N_L)) n_newest = lk_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) m_tag[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= m_tag[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbbc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_oldest    <= '0;
            r_newest    <= LW'(ENTRIES - 1);
            for (int i = 0; i < ENTRIES; i++) begin
                r_ref[i]   <= '0;
                r_newer[i] <= (i + 1 < ENTRIES) ? LW'(i + 1) : lbbc_pkg::LINK_NONE;
                r_older[i] <= (i > 0) ? LW'(i - 1) : lbbc_pkg::LINK_NONE;
            end
            for (int i = 0; i < lbbc_pkg::N_CNT; i++) r_cnt[i] <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_dirty  <= n_dirty;
            r_ref    <= n_ref;
            r_newer  <= n_newer;
            r_older  <= n_older;
            r_oldest <= n_oldest;
            r_newest <= n_newest;
            r_cnt    <= n_cnt;
            if (emit && out_free) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_e     <= n_e;
        r_ce    <= n_ce;
        r_steps <= n_steps;
        r_fst   <= n_fst;
        r_fent  <= n_fent;
        r_fdev  <= n_fdev;
        r_fblk  <= n_fblk;
        r_fhit  <= n_fhit;
        r_evict <= n_evict;
        if (emit && out_free) r_out <= n_out;
    end

    assign o_stall = (r_state != lbbc_pkg::S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== tb/sv/tb_lru_block_buffer_cache.sv =====
`timescale 1ns / 1ps

import lbbc_pkg::*;

class cache_scoreboard;
    localparam int NE = 32;
    localparam int ND = 16;
    localparam logic [7:0] REF_TOP = 8'hFF;

    logic [3:0]  tag_dev [NE];
    logic [63:0] tag_blk [NE];
    bit          valid_q [NE];
    bit          dirty_q [NE];
    bit          owned_q [NE];
    logic [7:0]  refs [NE];
    logic [5:0]  newer [NE];
    logic [5:0]  older [NE];
    logic [5:0]  oldest;
    logic [5:0]  newest;
    logic [31:0] counters [N_CNT];
    t_out        pending_results [$];
    int          mismatches;

    function new();
        mismatches = 0;
        for (int e = 0; e < NE; e++) begin
            tag_dev[e] = '0;
            tag_blk[e] = '0;
            valid_q[e] = 0;
            dirty_q[e] = 0;
            owned_q[e] = 0;
            refs[e] = '0;
            newer[e] = (e + 1 < NE) ? 6'(e + 1) : LINK_NONE;
            older[e] = (e > 0) ? 6'(e - 1) : LINK_NONE;
        end
        oldest = 6'd0;
        newest = 6'(NE - 1);
        for (int c = 0; c < N_CNT; c++) counters[c] = '0;
    endfunction

    function void bump(int c);
        if (counters[c] != 32'hFFFF_FFFF) counters[c]++;
    endfunction

    function void push_result(t_kind k, t_status st, int e, logic [3:0] d,
                              logic [63:0] b, bit hit);
        t_out r;
        r.kind = k;
        r.last = (k == KIND_FINAL);
        r.status = st;
        r.entry_out = 5'(e);
        r.xfer_device = d;
        r.xfer_block = b;
        r.hit_flag = hit;
        r.hits_total = counters[CNT_HIT];
        r.misses_total = counters[CNT_MISS];
        r.evictions_total = counters[CNT_EVICT];
        r.writebacks_total = counters[CNT_WB];
        r.failures_total = counters[CNT_FAIL];
        pending_results.push_back(r);
    endfunction

    function void unlink(int e);
        logic [5:0] o;
        logic [5:0] w;
        o = older[e];
        w = newer[e];
        if (w < NE) older[w] = o; else newest = o;
        if (o < NE) newer[o] = w; else oldest = w;
        older[e] = LINK_NONE;
        newer[e] = LINK_NONE;
    endfunction

    function void to_newest(int e);
        unlink(e);
        older[e] = newest;
        newer[e] = LINK_NONE;
        if (newest < NE) newer[newest] = 6'(e);
        newest = 6'(e);
        if (oldest >= NE) oldest = 6'(e);
    endfunction

    function void to_oldest(int e);
        unlink(e);
        newer[e] = oldest;
        older[e] = LINK_NONE;
        if (oldest < NE) older[oldest] = 6'(e);
        oldest = 6'(e);
        if (newest >= NE) newest = 6'(e);
    endfunction

    function void drop(int e);
        valid_q[e] = 0;
        dirty_q[e] = 0;
        owned_q[e] = 0;
        tag_dev[e] = '0;
        tag_blk[e] = '0;
    endfunction

    function bit write_back(int e, bit ok);
        if (!valid_q[e] || !dirty_q[e]) return 1;
        if (!ok) begin
            bump(CNT_FAIL);
            push_result(KIND_WB, ST_WFAIL, e, tag_dev[e], tag_blk[e], 0);
            return 0;
        end
        dirty_q[e] = 0;
        bump(CNT_WB);
        push_result(KIND_WB, ST_OK, e, tag_dev[e], tag_blk[e], 0);
        return 1;
    endfunction

    function void lookup(logic [3:0] d, logic [63:0] b, bit ok);
        int e;
        for (e = 0; e < NE; e++) begin
            if (valid_q[e] && tag_dev[e] == d && tag_blk[e] == b) begin
                bump(CNT_HIT);
                to_newest(e);
                if (refs[e] < REF_TOP) refs[e]++;
                push_result(KIND_FINAL, ST_OK, e, d, b, 1);
                return;
            end
        end
        bump(CNT_MISS);
        e = oldest;
        for (int s = 0; e < NE && s < NE; s++) begin
            if (refs[e] == 0) break;
            e = newer[e];
        end
        if (e >= NE || refs[e] != 0) begin
            push_result(KIND_FINAL, ST_NOFREE, 0, '0, '0, 0);
            return;
        end
        if (valid_q[e]) begin
            if (!write_back(e, ok)) begin
                push_result(KIND_FINAL, ST_WFAIL, 0, '0, '0, 0);
                return;
            end
            bump(CNT_EVICT);
        end
        drop(e);
        if (!ok) begin
            bump(CNT_FAIL);
            push_result(KIND_READ, ST_RFAIL, e, d, b, 0);
            push_result(KIND_FINAL, ST_RFAIL, 0, '0, '0, 0);
            return;
        end
        push_result(KIND_READ, ST_OK, e, d, b, 0);
        tag_dev[e] = d;
        tag_blk[e] = b;
        valid_q[e] = 1;
        owned_q[e] = 1;
        refs[e] = 8'd1;
        to_newest(e);
        push_result(KIND_FINAL, ST_OK, e, d, b, 0);
    endfunction

    function t_status invalidate(logic [3:0] d, bit ok);
        t_status st;
        st = ST_OK;
        for (int e = 0; e < NE; e++)
            if (owned_q[e] && tag_dev[e] == d && refs[e] != 0) return ST_HELD;
        for (int e = 0; e < NE; e++) begin
            if (!owned_q[e] || tag_dev[e] != d) continue;
            if (!write_back(e, ok)) begin
                st = ST_WFAIL;
                continue;
            end
            drop(e);
            to_oldest(e);
        end
        return st;
    endfunction

    function void note_request(t_in req);
        t_status st;
        int idx;
        st = ST_OK;
        idx = req.entry_index;
        case (req.func)
            FN_GET: begin
                if (!req.size_ok || req.device_id >= ND) begin
                    push_result(KIND_FINAL, ST_NOCACHE, 0, '0, '0, 0);
                    return;
                end
                lookup(req.device_id, req.block_number, req.device_ok);
                return;
            end
            FN_RELEASE: if (idx < NE && refs[idx] != 0) refs[idx]--;
            FN_DIRTY: if (idx < NE && valid_q[idx]) dirty_q[idx] = 1;
            FN_FLUSH: begin
                if (idx >= NE) st = ST_WFAIL;
                else if (!write_back(idx, req.device_ok)) st = ST_WFAIL;
            end
            FN_SYNC: begin
                for (int e = 0; e < NE; e++)
                    if (!write_back(e, req.device_ok)) st = ST_WFAIL;
            end
            FN_INVAL: if (req.device_id < ND) st = invalidate(req.device_id, req.device_ok);
            default: ;
        endcase
        push_result(KIND_FINAL, st, 0, '0, '0, 0);
    endfunction

    function void check_result(t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected %h", want);
                $display("          actual   %h", got);
            end
        end
    endfunction
endclass

module tb_lru_block_buffer_cache;
    localparam int IDLE_PCT = 12;
    localparam int WATCHDOG = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    cache_scoreboard sb;
    bit   sink_quiet;
    bit   hold_sink;
    int   idle_cycles;
    logic [63:0] recent_blocks [8];
    logic [3:0]  recent_devs [8];

    lru_block_buffer_cache dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Scoreboard updates happen on the edge that accepts each transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_data);
            if (o_valid && !i_stall) sb.check_result(o_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_lru_block_buffer_cache: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_sink) i_stall <= 1'b1;
        else if (sink_quiet) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send(t_in req);
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (!sink_quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in make_req(t_func f, logic [3:0] d, logic [63:0] b,
                                     logic [4:0] idx, bit sz, bit ok);
        t_in r;
        r.func = f;
        r.device_id = d;
        r.block_number = b;
        r.entry_index = idx;
        r.size_ok = sz;
        r.device_ok = ok;
        return r;
    endfunction

    // Mostly reuses a small pool of tags so hits, evictions and held entries occur.
    function automatic t_in random_req();
        t_in r;
        int k;
        int p;
        k = $urandom_range(7);
        p = $urandom_range(99);
        r = make_req(FN_GET, recent_devs[k], recent_blocks[k], 5'($urandom),
                     ($urandom_range(19) != 0), ($urandom_range(9) != 0));
        if (p < 10) begin
            r.block_number = {$urandom, $urandom};
            r.device_id = 4'($urandom);
        end else if (p < 45) begin
            r.func = FN_GET;
        end else if (p < 68) begin
            r.func = FN_RELEASE;
        end else if (p < 80) begin
            r.func = FN_DIRTY;
        end else if (p < 88) begin
            r.func = FN_FLUSH;
        end else if (p < 92) begin
            r.func = FN_SYNC;
        end else if (p < 97) begin
            r.func = FN_INVAL;
        end else begin
            r.func = 3'($urandom_range(6, 7));
        end
        return r;
    endfunction

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b1;
        i_data = '0;
        sink_quiet = 1'b0;
        hold_sink = 1'b0;
        idle_cycles = 0;
        for (int k = 0; k < 8; k++) begin
            recent_blocks[k] = (k == 7) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(k * 3);
            recent_devs[k] = (k == 7) ? 4'hF : 4'(k % 3);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        send(make_req(FN_GET, 4'd0, 64'd0, 5'd0, 1'b0, 1'b1));
        send(make_req(FN_GET, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_GET, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_GET, 4'd1, 64'd5, 5'd0, 1'b1, 1'b0));
        send(make_req(FN_GET, 4'd1, 64'd5, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_DIRTY, 4'd0, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_DIRTY, 4'd0, 64'd0, 5'd31, 1'b1, 1'b1));
        send(make_req(FN_FLUSH, 4'd0, 64'd0, 5'd0, 1'b1, 1'b0));
        send(make_req(FN_SYNC, 4'd0, 64'd0, 5'd0, 1'b1, 1'b0));
        send(make_req(FN_INVAL, 4'hF, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_RELEASE, 4'd0, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_RELEASE, 4'd0, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_RELEASE, 4'd0, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_INVAL, 4'hF, 64'd0, 5'd0, 1'b1, 1'b0));
        send(make_req(FN_SYNC, 4'd0, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(FN_FLUSH, 4'd0, 64'd0, 5'd1, 1'b1, 1'b1));
        send(make_req(FN_INVAL, 4'hF, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(3'd6, 4'd0, 64'd0, 5'd0, 1'b1, 1'b1));
        send(make_req(3'd7, 4'hA, 64'hAAAA_5555_AAAA_5555, 5'd21, 1'b0, 1'b0));
        // Hold every entry so a miss finds none free, then evict a dirty victim.
        for (int k = 0; k < 33; k++)
            send(make_req(FN_GET, 4'd2, 64'(100 + k), 5'd0, 1'b1, 1'b1));
        send(make_req(FN_RELEASE, 4'd0, 64'd0, 5'd3, 1'b1, 1'b1));
        send(make_req(FN_DIRTY, 4'd0, 64'd0, 5'd3, 1'b1, 1'b1));
        send(make_req(FN_GET, 4'd2, 64'd999, 5'd0, 1'b1, 1'b0));
        send(make_req(FN_GET, 4'd2, 64'd999, 5'd0, 1'b1, 1'b1));
        for (int k = 0; k < 32; k++)
            send(make_req(FN_RELEASE, 4'd0, 64'd0, 5'(k), 1'b1, 1'b1));
        drain();

        // The sender pauses here until all results are in, then the receiver holds off.
        hold_sink = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int k = 0; k < 6; k++) send(random_req());
        join

        for (int n = 0; n < 116; n++) begin
            sink_quiet = (n >= 80 && n < 120);
            send(random_req());
        end
        sink_quiet = 1'b0;
        drain();
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb_lru_block_buffer_cache: PASS");
        else
            $display("tb_lru_block_buffer_cache: FAIL");
        $finish;
    end
endmodule
